@@ rtl/core/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types, constants and the sequencer program for the load search.
// ----------------------------------------------------------------------------
package sls_pkg;

	localparam int WEIGHT_W = 16;
	localparam int LOAD_W   = 20;
	localparam int SUM_W    = LOAD_W + 1;
	localparam int MASK_W   = 32;
	localparam int IDX_W    = 5;
	localparam int CNT_W    = 6;
	localparam int STEP_W   = 4;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                is_last;
	} item_t;

	typedef struct packed {
		logic [LOAD_W-1:0] best_load;
		logic [MASK_W-1:0] chosen_mask;
		logic              too_many;
	} result_t;

	typedef logic [STEP_W-1:0] step_t;

	// program steps
	localparam step_t S_IDLE  = 4'd0;
	localparam step_t S_INIT  = 4'd1;
	localparam step_t S_VISIT = 4'd2;
	localparam step_t S_FETCH = 4'd3;
	localparam step_t S_INCL  = 4'd4;
	localparam step_t S_EXCL  = 4'd5;
	localparam step_t S_EXGO  = 4'd6;
	localparam step_t S_LEAF  = 4'd7;
	localparam step_t S_POP   = 4'd8;
	localparam step_t S_RET   = 4'd9;
	localparam step_t S_UNINC = 4'd10;
	localparam step_t S_UNBD  = 4'd11;
	localparam step_t S_DONE  = 4'd12;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_START,
		C_LEAF,
		C_NOFIT,
		C_NO_EXCL,
		C_D_ZERO,
		C_BD_SET
	} cond_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_INCL,
		OP_SET_BD,
		OP_DEPTH_UP,
		OP_LEAF,
		OP_DEPTH_DN,
		OP_UNINC,
		OP_CLR_BD,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  rd;
	} ucode_t;

	// control store: jump to target when cond holds, else fall through
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		case (pc)
			S_IDLE:  w = '{op: OP_NONE,     cond: C_NO_START, target: S_IDLE,  rd: 1'b0};
			S_INIT:  w = '{op: OP_INIT,     cond: C_NEXT,     target: S_IDLE,  rd: 1'b0};
			S_VISIT: w = '{op: OP_NONE,     cond: C_LEAF,     target: S_LEAF,  rd: 1'b1};
			S_FETCH: w = '{op: OP_NONE,     cond: C_NOFIT,    target: S_EXCL,  rd: 1'b0};
			S_INCL:  w = '{op: OP_INCL,     cond: C_ALWAYS,   target: S_VISIT, rd: 1'b0};
			S_EXCL:  w = '{op: OP_SET_BD,   cond: C_NO_EXCL,  target: S_POP,   rd: 1'b0};
			S_EXGO:  w = '{op: OP_DEPTH_UP, cond: C_ALWAYS,   target: S_VISIT, rd: 1'b0};
			S_LEAF:  w = '{op: OP_LEAF,     cond: C_NEXT,     target: S_IDLE,  rd: 1'b0};
			S_POP:   w = '{op: OP_DEPTH_DN, cond: C_D_ZERO,   target: S_DONE,  rd: 1'b0};
			S_RET:   w = '{op: OP_NONE,     cond: C_BD_SET,   target: S_UNBD,  rd: 1'b1};
			S_UNINC: w = '{op: OP_UNINC,    cond: C_ALWAYS,   target: S_EXCL,  rd: 1'b0};
			S_UNBD:  w = '{op: OP_CLR_BD,   cond: C_ALWAYS,   target: S_POP,   rd: 1'b0};
			S_DONE:  w = '{op: OP_EMIT,     cond: C_ALWAYS,   target: S_IDLE,  rd: 1'b0};
			default: w = '{op: OP_NONE,     cond: C_ALWAYS,   target: S_IDLE,  rd: 1'b0};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/sls_ram.sv @@
// ----------------------------------------------------------------------------
// sls_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// output holds while no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/subset_load_search.sv @@
// ----------------------------------------------------------------------------
// subset_load_search
// Loads item weights, then runs a depth-first include-first search for the
// largest total load that fits the capacity, under a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | signals                        | transfer
//  ---------+--------------------------------+-------------------------------
//  input    | start, busy, item              | start high while busy low
//  result   | done, result                   | done high, one cycle, no stall
//  config   | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
//  weights arrive one per accepted transfer; the item marked is_last starts
//  the search; a leaf runs steps VISIT and LEAF, an inner node VISIT, FETCH,
//  INCL for the load-item branch, EXCL and EXGO for the leave-item branch,
//  and POP, RET and UNINC or UNBD on each return, with a weight store read
//  ahead of every fit check and every back out; up to 2^(N+1)-1 tree nodes
//  for N stored items; a setup step before the search, an emit step after it;
//  the result strobe comes in the first idle cycle, when busy is already low
//  busy stays high through the search; reset clears all control state, the
//  weight store is not cleared; the result receiver cannot stall
//
module subset_load_search #(
	parameter int MAX_ITEMS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item transfer
	input  logic                         start,
	output logic                         busy,
	input  sls_pkg::item_t               item,
	// result transfer
	output logic                         done,
	output sls_pkg::result_t             result,
	// capacity register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sls_pkg::LOAD_W-1:0]   cfg_data
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// sequencer
	sls_pkg::step_t  pc_q;
	sls_pkg::ucode_t uw;
	logic            jump;

	// datapath registers
	logic [sls_pkg::LOAD_W-1:0]   capacity_q;
	logic [sls_pkg::CNT_W-1:0]    count_q;
	logic                         ovf_q;
	logic [sls_pkg::CNT_W-1:0]    depth_q;
	logic [sls_pkg::MASK_W-1:0]   path_q;
	logic [sls_pkg::MASK_W-1:0]   bd_q;
	logic [sls_pkg::SUM_W-1:0]    load_q;
	logic [sls_pkg::LOAD_W-1:0]   best_q;
	logic                         best_valid_q;
	logic [sls_pkg::MASK_W-1:0]   best_path_q;
	logic                         done_q;
	sls_pkg::result_t             result_q;

	// store access
	logic                         accept;
	logic                         store_we;
	logic [sls_pkg::WEIGHT_W-1:0] rdata;
	logic [sls_pkg::IDX_W-1:0]    didx;

	// conditions
	logic [sls_pkg::SUM_W-1:0]    fit_sum;
	logic                         fits;
	logic                         no_excl;
	logic                         is_leaf;

	assign uw        = sls_pkg::ucode_rom(pc_q);
	assign busy      = (pc_q != sls_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign accept   = start && !busy;
	assign store_we = accept && (count_q < sls_pkg::CNT_W'(MAX_ITEMS));
	assign didx     = depth_q[sls_pkg::IDX_W-1:0];

	// load + weight against capacity; a weight is added to load only when the sum fits
	assign fit_sum = load_q + sls_pkg::SUM_W'(rdata);
	assign fits    = (fit_sum <= sls_pkg::SUM_W'(capacity_q));
	// leave-item branch only while no best exists yet or capacity is above the best so far
	assign no_excl = best_valid_q && !(capacity_q > best_q);
	assign is_leaf = (depth_q >= count_q);

	always_comb begin
		case (uw.cond)
			sls_pkg::C_NEXT:     jump = 1'b0;
			sls_pkg::C_ALWAYS:   jump = 1'b1;
			sls_pkg::C_NO_START: jump = !(accept && item.is_last);
			sls_pkg::C_LEAF:     jump = is_leaf;
			sls_pkg::C_NOFIT:    jump = !fits;
			sls_pkg::C_NO_EXCL:  jump = no_excl;
			sls_pkg::C_D_ZERO:   jump = (depth_q == '0);
			sls_pkg::C_BD_SET:   jump = bd_q[didx];
			default:             jump = 1'b1;
		endcase
	end

	sls_ram #(
		.WIDTH (sls_pkg::WEIGHT_W),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (item.weight),
		.re    (uw.rd),
		.raddr (depth_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= sls_pkg::S_IDLE;
			capacity_q   <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			depth_q      <= '0;
			path_q       <= '0;
			bd_q         <= '0;
			load_q       <= '0;
			best_q       <= '0;
			best_valid_q <= 1'b0;
			best_path_q  <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			pc_q   <= jump ? uw.target : pc_q + 1'b1;
			done_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end

			// weight transfer: store it, or flag a full store
			if (accept) begin
				if (store_we) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			case (uw.op)
				sls_pkg::OP_NONE: begin
				end
				sls_pkg::OP_INIT: begin
					depth_q      <= '0;
					path_q       <= '0;
					bd_q         <= '0;
					load_q       <= '0;
					best_q       <= '0;
					best_valid_q <= 1'b0;
					best_path_q  <= '0;
				end
				sls_pkg::OP_INCL: begin
					path_q[didx] <= 1'b1;
					load_q       <= fit_sum;
					depth_q      <= depth_q + 1'b1;
				end
				sls_pkg::OP_SET_BD: begin
					bd_q[didx] <= 1'b1;
				end
				sls_pkg::OP_DEPTH_UP: begin
					depth_q <= depth_q + 1'b1;
				end
				sls_pkg::OP_LEAF: begin
					// strictly larger wins, ties keep the first leaf
					if (!best_valid_q || (load_q > sls_pkg::SUM_W'(best_q))) begin
						best_q       <= load_q[sls_pkg::LOAD_W-1:0];
						best_path_q  <= path_q;
						best_valid_q <= 1'b1;
					end
				end
				sls_pkg::OP_DEPTH_DN: begin
					depth_q <= depth_q - 1'b1;
				end
				sls_pkg::OP_UNINC: begin
					// back out of the load-item branch
					load_q       <= load_q - sls_pkg::SUM_W'(rdata);
					path_q[didx] <= 1'b0;
				end
				sls_pkg::OP_CLR_BD: begin
					bd_q[didx] <= 1'b0;
				end
				sls_pkg::OP_EMIT: begin
					done_q               <= 1'b1;
					result_q.best_load   <= best_q;
					result_q.chosen_mask <= best_path_q;
					result_q.too_many    <= ovf_q;
					count_q              <= '0;
					ovf_q                <= 1'b0;
					depth_q              <= '0;
					path_q               <= '0;
					bd_q                 <= '0;
					load_q               <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
